// ===== sv/fault_qualify_latch_indicator_assert.svh =====
// assertion macros for the fault qualify latch indicator
`ifndef FAULT_QUALIFY_LATCH_INDICATOR_ASSERT_SVH
`define FAULT_QUALIFY_LATCH_INDICATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FQLI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fqli check failed");

// next-cycle implication, checked out of reset
`define FQLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fqli check failed");

`endif

// ===== sv/fqli_pkg.sv =====
`default_nettype none

package fqli_pkg;

    localparam logic [5:0]  QualifyCountReset = 6'd20;
    localparam logic [5:0]  ReleaseCountReset = 6'd40;
    localparam logic [15:0] BlinkHalfReset    = 16'd10000;

    typedef enum logic [1:0] {
        CFG_QUALIFY = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_BLINK   = 2'd2
    } cfg_index_t;

    // first field in the highest bit
    typedef struct packed {
        logic timer_tick;
        logic clear_button;
        logic imd_gate_line;
        logic bms_fault_line;
    } item_t;

    typedef struct packed {
        logic fault_latched;
        logic fault_active;
        logic green_led;
        logic red_led;
        logic relay_drive;
    } result_t;

    typedef struct packed {
        logic [5:0]  qualify_count;
        logic [5:0]  release_count;
        logic [15:0] blink_half_period;
    } cfg_t;

    // 64 is 1 mod 9, so folding 6-bit chunks keeps the residue
    function automatic logic mod9_zero(input logic [15:0] v);
        logic [7:0] s1;
        logic [6:0] s2;
        s1 = {2'b00, v[5:0]} + {2'b00, v[11:6]} + {4'b0000, v[15:12]};
        s2 = {1'b0, s1[5:0]} + {5'b00000, s1[7:6]};
        return (s2 == 7'd0)  || (s2 == 7'd9)  || (s2 == 7'd18) || (s2 == 7'd27) ||
               (s2 == 7'd36) || (s2 == 7'd45) || (s2 == 7'd54) || (s2 == 7'd63);
    endfunction

endpackage

`default_nettype wire

// ===== sv/fqli_cfg_regs.sv =====
`default_nettype none

module fqli_cfg_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_wdata,
    output fqli_pkg::cfg_t     cfg
);
    import fqli_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_QUALIFY: cfg_next.qualify_count     = cfg_wdata[5:0];
                CFG_RELEASE: cfg_next.release_count     = cfg_wdata[5:0];
                CFG_BLINK:   cfg_next.blink_half_period = cfg_wdata;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.qualify_count     <= QualifyCountReset;
            cfg_reg.release_count     <= ReleaseCountReset;
            cfg_reg.blink_half_period <= BlinkHalfReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/fqli_step.sv =====
`default_nettype none

module fqli_step (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  fqli_pkg::item_t    item,
    input  fqli_pkg::cfg_t     cfg,
    output fqli_pkg::result_t  result
);
    import fqli_pkg::*;

    logic [5:0]  qcnt_reg;
    logic        fault_reg;
    logic        latch_reg;
    logic [15:0] tick_reg;
    logic        red_reg;
    logic        green_reg;

    logic [5:0]  qcnt_next;
    logic        fault_next;
    logic        latch_next;
    logic [15:0] tick_next;
    logic        red_next;
    logic        green_next;
    logic        potential;

    always_comb begin
        qcnt_next  = qcnt_reg;
        fault_next = fault_reg;
        latch_next = latch_reg;
        tick_next  = tick_reg;
        red_next   = red_reg;
        green_next = green_reg;
        potential  = item.bms_fault_line | ~item.imd_gate_line;

        // qualify / release counter
        if (potential) begin
            if (qcnt_next < cfg.qualify_count) begin
                qcnt_next = qcnt_next + 6'd1;
            end else if (qcnt_next == cfg.qualify_count) begin
                fault_next = 1'b1;
            end else begin
                qcnt_next = '0;
            end
        end else begin
            if (qcnt_next < cfg.qualify_count) begin
                qcnt_next = '0;
            end
            if (qcnt_next < cfg.release_count) begin
                qcnt_next = qcnt_next + 6'd1;
            end else begin
                fault_next = 1'b0;
                qcnt_next  = '0;
            end
        end

        if (item.clear_button && !fault_next) begin
            latch_next = 1'b0;
        end

        // blink and dim pulse
        if (item.timer_tick) begin
            tick_next = tick_next + 16'd1;
            if ((fault_next || latch_next) && (tick_next >= cfg.blink_half_period)) begin
                qcnt_next  = '0;
                tick_next  = '0;
                red_next   = ~red_next;
                green_next = 1'b0;
                latch_next = 1'b1;
            end
            if (!latch_next && !tick_next[0]) begin
                green_next = mod9_zero(tick_next);
                red_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qcnt_reg  <= '0;
            fault_reg <= 1'b0;
            latch_reg <= 1'b0;
            tick_reg  <= '0;
            red_reg   <= 1'b0;
            green_reg <= 1'b0;
        end else if (step_en) begin
            qcnt_reg  <= qcnt_next;
            fault_reg <= fault_next;
            latch_reg <= latch_next;
            tick_reg  <= tick_next;
            red_reg   <= red_next;
            green_reg <= green_next;
        end
    end

    assign result.relay_drive   = ~item.bms_fault_line;
    assign result.red_led       = red_next;
    assign result.green_led     = green_next;
    assign result.fault_active  = fault_next;
    assign result.fault_latched = latch_next;

endmodule

`default_nettype wire

// ===== sv/fault_qualify_latch_indicator.sv =====
// path: an accepted input beat is held in the input register, its result in the output register on m_tvalid
// throughput: one beat per cycle, s_tready drops only when both registers are full
// and m_tready is low
// reset (aresetn low, synchronous): counters, fault, latch and leds clear,
// registers return to qualify 20, release 40, half period 10000, both sides empty
`default_nettype none

module fault_qualify_latch_indicator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output wire logic        s_tready,
    // bms_fault_line, imd_gate_line, clear_button, timer_tick, zero fill
    input  wire logic [7:0]  s_tdata,
    output wire logic        m_tvalid,
    input  wire logic        m_tready,
    // relay_drive, red_led, green_led, fault_active, fault_latched, zero fill
    output wire logic [7:0]  m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import fqli_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    logic    advance;
    cfg_t    cfg;
    result_t step_result;

    fqli_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fqli_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= item_t'(s_tdata[3:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg};

`include "fault_qualify_latch_indicator_assert.svh"

    `FQLI_ASSERT_NOW(a_stall_blocks_input, in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    `FQLI_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_reg)
    `FQLI_ASSERT_NEXT(a_relay_follows_bms, advance,
        out_result_reg.relay_drive == !$past(in_item_reg.bms_fault_line))

endmodule

`default_nettype wire
